>>> rtl/sbt_pkg.sv
// sbt_pkg: shared types, constants and codes of the script byte tokenizer
// no dependencies; imported by every other file of the block
package sbt_pkg;

	localparam int BYTE_BITS     = 8;
	localparam int LINE_BITS     = 24;
	localparam int LINE_OUT_BITS = 24;
	localparam int NUM_BITS      = 32;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_LSB   = 2;

	localparam logic [BYTE_BITS-1:0] COMMENT_RESET = 8'd59;
	localparam logic [BYTE_BITS-1:0] QUOTE_RESET   = 8'd34;
	localparam logic [BYTE_BITS-1:0] SPACE_BYTE    = 8'd32;
	localparam logic [BYTE_BITS-1:0] NL_BYTE       = 8'd10;

	localparam logic [NUM_BITS-1:0] MAG_CAP = 32'h8000_0000;
	localparam logic [NUM_BITS-1:0] POS_MAX = 32'h7fff_ffff;

	typedef enum logic [1:0] {
		MODE_GAP     = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_PLAIN   = 2'd2,
		MODE_QUOTED  = 2'd3
	} lex_mode_t;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_SIGN   = 3'd1,
		PH_ZERO   = 3'd2,
		PH_HEXPFX = 3'd3,
		PH_DEC    = 3'd4,
		PH_OCT    = 3'd5,
		PH_HEX    = 3'd6,
		PH_BAD    = 3'd7
	} num_phase_t;

	typedef enum logic {
		CFG_COMMENT = 1'b0,
		CFG_QUOTE   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] comment_char;
		logic [BYTE_BITS-1:0] quote_char;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] byte_value;
		logic                 first_of_script;
		logic                 last_of_script;
	} byte_beat_t;

	typedef struct packed {
		num_phase_t          phase;
		logic                negative;
		logic [NUM_BITS-1:0] accum;
		logic                saturated;
	} num_state_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0]     token_char;
		logic                     char_valid;
		logic                     token_first;
		logic                     token_last;
		logic                     newline_before;
		logic [LINE_OUT_BITS-1:0] line_number;
		logic signed [NUM_BITS-1:0] number_value;
		logic                     number_valid;
	} token_t;

endpackage

>>> rtl/sbt_byte_if.sv
// sbt_byte_if: input channel of the tokenizer, one script byte per beat
// depends on sbt_pkg
interface sbt_byte_if;
	import sbt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [BYTE_BITS-1:0] byte_value;
	logic                 first_of_script;
	logic                 last_of_script;

	modport source (output valid, output byte_value, output first_of_script,
		output last_of_script, input ready);
	modport sink (input valid, input byte_value, input first_of_script,
		input last_of_script, output ready);
endinterface

>>> rtl/sbt_token_if.sv
// sbt_token_if: output channel of the tokenizer, one token result per beat
// depends on sbt_pkg
interface sbt_token_if;
	import sbt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [BYTE_BITS-1:0]       token_char;
	logic                       char_valid;
	logic                       token_first;
	logic                       token_last;
	logic                       newline_before;
	logic [LINE_OUT_BITS-1:0]   line_number;
	logic signed [NUM_BITS-1:0] number_value;
	logic                       number_valid;

	modport source (output valid, output token_char, output char_valid,
		output token_first, output token_last, output newline_before,
		output line_number, output number_value, output number_valid, input ready);
	modport sink (input valid, input token_char, input char_valid,
		input token_first, input token_last, input newline_before,
		input line_number, input number_value, input number_valid, output ready);
endinterface

>>> rtl/sbt_cfg_regs.sv
// sbt_cfg_regs: apb register file holding comment and quote characters
// depends on sbt_pkg
module sbt_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbt_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [sbt_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [sbt_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                             pready,
	output sbt_pkg::cfg_t                    cfg
);
	import sbt_pkg::*;

	cfg_idx_t idx;
	logic     wr;
	cfg_t     cfg_q;

	assign idx    = cfg_idx_t'(paddr[CFG_IDX_LSB]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.comment_char <= COMMENT_RESET;
			cfg_q.quote_char   <= QUOTE_RESET;
		end else if (wr) begin
			case (idx)
				CFG_COMMENT: cfg_q.comment_char <= pwdata[BYTE_BITS-1:0];
				CFG_QUOTE:   cfg_q.quote_char   <= pwdata[BYTE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			CFG_COMMENT: prdata = CFG_DATA_BITS'(cfg_q.comment_char);
			CFG_QUOTE:   prdata = CFG_DATA_BITS'(cfg_q.quote_char);
			default:     prdata = '0;
		endcase
	end
endmodule

>>> rtl/sbt_number_unit.sv
// sbt_number_unit: one step of the base-0 integer conversion, saturating
// depends on sbt_pkg
module sbt_number_unit (
	input  sbt_pkg::num_state_t              base,
	input  logic [sbt_pkg::BYTE_BITS-1:0]     byte_value,
	input  logic                             feed,
	output sbt_pkg::num_state_t              nxt_state,
	output logic signed [sbt_pkg::NUM_BITS-1:0] value,
	output logic                             is_int,
	output logic                             at_start
);
	import sbt_pkg::*;

	localparam logic [BYTE_BITS-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_BITS-1:0] CH_7     = 8'h37;
	localparam logic [BYTE_BITS-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_BITS-1:0] CH_LA    = 8'h61;
	localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h66;
	localparam logic [BYTE_BITS-1:0] CH_UA    = 8'h41;
	localparam logic [BYTE_BITS-1:0] CH_UF    = 8'h46;
	localparam logic [BYTE_BITS-1:0] CH_LX    = 8'h78;
	localparam logic [BYTE_BITS-1:0] CH_UX    = 8'h58;
	localparam logic [BYTE_BITS-1:0] CH_PLUS  = 8'h2b;
	localparam logic [BYTE_BITS-1:0] CH_MINUS = 8'h2d;
	localparam int WIDE_BITS = NUM_BITS + 4;

	typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_t;

	function automatic logic [4:0] hex_digit(input logic [BYTE_BITS-1:0] b);
		if (b >= CH_0 && b <= CH_9) return {1'b0, b[3:0]};
		if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF))
			return 5'(b[3:0]) + 5'd9;
		return 5'd16;
	endfunction

	logic [4:0]           digit;
	logic                 is_dec, is_oct, is_hex, is_space, lead, acc_req;
	radix_t               radix;
	logic [WIDE_BITS-1:0] scaled, sum;
	num_state_t           fed;
	logic [NUM_BITS-1:0]  mag;

	always_comb begin
		digit    = hex_digit(byte_value);
		is_dec   = byte_value >= CH_0 && byte_value <= CH_9;
		is_oct   = byte_value >= CH_0 && byte_value <= CH_7;
		is_hex   = !digit[4];
		is_space = byte_value == SPACE_BYTE || (byte_value >= 8'd9 && byte_value <= 8'd13);
		lead     = 1'b0;
		acc_req  = 1'b0;
		radix    = RADIX_DEC;
		fed      = base;

		case (base.phase)
			PH_START: begin
				if (is_space) begin
				end else if (byte_value == CH_PLUS) begin
					fed.phase = PH_SIGN;
				end else if (byte_value == CH_MINUS) begin
					fed.negative = 1'b1;
					fed.phase    = PH_SIGN;
				end else begin
					lead = 1'b1;
				end
			end
			PH_SIGN: lead = 1'b1;
			PH_ZERO: begin
				if (byte_value == CH_LX || byte_value == CH_UX) begin
					fed.phase = PH_HEXPFX;
				end else if (is_oct) begin
					acc_req   = 1'b1;
					radix     = RADIX_OCT;
					fed.phase = PH_OCT;
				end else begin
					fed.phase = PH_BAD;
				end
			end
			PH_HEXPFX, PH_HEX: begin
				if (is_hex) begin
					acc_req   = 1'b1;
					radix     = RADIX_HEX;
					fed.phase = PH_HEX;
				end else begin
					fed.phase = PH_BAD;
				end
			end
			PH_DEC: begin
				if (is_dec) acc_req = 1'b1;
				else fed.phase = PH_BAD;
			end
			PH_OCT: begin
				radix = RADIX_OCT;
				if (is_oct) acc_req = 1'b1;
				else fed.phase = PH_BAD;
			end
			default: fed.phase = PH_BAD;
		endcase

		// leading digit after optional sign
		if (lead) begin
			if (byte_value == CH_0) begin
				fed.phase = PH_ZERO;
			end else if (is_dec) begin
				acc_req   = 1'b1;
				fed.phase = PH_DEC;
			end else begin
				fed.phase = PH_BAD;
			end
		end

		// accum times radix by shifts, then add the digit
		case (radix)
			RADIX_HEX: scaled = {base.accum, 4'b0000};
			RADIX_OCT: scaled = {1'b0, base.accum, 3'b000};
			default:   scaled = {1'b0, base.accum, 3'b000} + {3'b000, base.accum, 1'b0};
		endcase
		sum = scaled + WIDE_BITS'(digit[3:0]);

		if (acc_req) begin
			if (base.saturated || sum > WIDE_BITS'(MAG_CAP)) begin
				fed.accum     = MAG_CAP;
				fed.saturated = 1'b1;
			end else begin
				fed.accum = sum[NUM_BITS-1:0];
			end
		end

		nxt_state = feed ? fed : base;

		if (nxt_state.negative)
			mag = (nxt_state.accum >= MAG_CAP) ? MAG_CAP : (NUM_BITS'(0) - nxt_state.accum);
		else
			mag = (nxt_state.accum > POS_MAX) ? POS_MAX : nxt_state.accum;
		value = signed'(mag);

		is_int   = nxt_state.phase == PH_ZERO || nxt_state.phase == PH_DEC ||
			nxt_state.phase == PH_OCT || nxt_state.phase == PH_HEX;
		at_start = nxt_state.phase == PH_START;
	end
endmodule

>>> rtl/sbt_lex_core.sv
// sbt_lex_core: lexer state registers and the per-byte token decision
// depends on sbt_pkg and sbt_number_unit
module sbt_lex_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  sbt_pkg::byte_beat_t beat,
	input  sbt_pkg::cfg_t       cfg,
	output logic                emit,
	output sbt_pkg::token_t     result
);
	import sbt_pkg::*;

	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

	lex_mode_t           mode_q, mode_eff, mode_n;
	logic [LINE_BITS-1:0] line_q, line_eff, line_n, line_inc;
	logic                nl_q, nl_eff, nl_n;
	logic                fp_q, fp_eff, fp_n;
	num_state_t          num_q, num_base, num_n, num_clear;
	logic [BYTE_BITS-1:0] b;
	logic                is_ws, is_cc, is_qc, is_nl, last;
	logic                clear_num, do_feed, cv, tf, tl;
	logic signed [NUM_BITS-1:0] num_value;
	logic                num_int, num_start;
	logic [31:0]         line_wide;

	assign num_clear = '{phase: PH_START, negative: 1'b0, accum: '0, saturated: 1'b0};

	sbt_number_unit u_num (
		.base       (num_base),
		.byte_value (b),
		.feed       (do_feed),
		.nxt_state  (num_n),
		.value      (num_value),
		.is_int     (num_int),
		.at_start   (num_start)
	);

	always_comb begin
		b     = beat.byte_value;
		last  = beat.last_of_script;
		is_ws = b <= SPACE_BYTE;
		is_cc = b == cfg.comment_char;
		is_qc = b == cfg.quote_char;
		is_nl = b == NL_BYTE;

		// script restart
		mode_eff = beat.first_of_script ? MODE_GAP : mode_q;
		line_eff = beat.first_of_script ? LINE_ONE : line_q;
		nl_eff   = beat.first_of_script ? 1'b0 : nl_q;
		fp_eff   = beat.first_of_script ? 1'b0 : fp_q;
		line_inc = (line_eff == LINE_MAX) ? line_eff : line_eff + LINE_ONE;

		// a new token or quote from the gap starts a fresh conversion
		clear_num = beat.first_of_script || (mode_eff == MODE_GAP && !is_ws && !is_cc);
		num_base  = clear_num ? num_clear : num_q;

		emit    = 1'b0;
		cv      = 1'b0;
		tf      = 1'b0;
		tl      = 1'b0;
		do_feed = 1'b0;
		mode_n  = mode_eff;
		line_n  = line_eff;
		nl_n    = nl_eff;
		fp_n    = fp_eff;

		case (mode_eff)
			MODE_COMMENT: begin
				if (is_nl) begin
					line_n = line_inc;
					nl_n   = 1'b1;
					mode_n = MODE_GAP;
				end
			end
			MODE_PLAIN: begin
				if (is_ws || is_cc) begin
					emit = 1'b1;
					tl   = 1'b1;
					nl_n = 1'b0;
					if (is_ws) begin
						mode_n = MODE_GAP;
						if (is_nl) begin
							line_n = line_inc;
							nl_n   = 1'b1;
						end
					end else begin
						mode_n = MODE_COMMENT;
					end
				end else begin
					do_feed = 1'b1;
					emit    = 1'b1;
					cv      = 1'b1;
					tl      = last;
				end
			end
			MODE_QUOTED: begin
				emit = 1'b1;
				tf   = fp_eff;
				fp_n = 1'b0;
				if (is_qc) begin
					tl     = 1'b1;
					nl_n   = 1'b0;
					mode_n = MODE_GAP;
				end else begin
					do_feed = 1'b1;
					cv      = 1'b1;
					tl      = last;
				end
			end
			default: begin
				if (is_ws) begin
					if (is_nl) begin
						line_n = line_inc;
						nl_n   = 1'b1;
					end
				end else if (is_cc) begin
					mode_n = MODE_COMMENT;
				end else if (is_qc) begin
					if (last) begin
						emit = 1'b1;
						tf   = 1'b1;
						tl   = 1'b1;
					end else begin
						mode_n = MODE_QUOTED;
						fp_n   = 1'b1;
					end
				end else begin
					do_feed = 1'b1;
					emit    = 1'b1;
					cv      = 1'b1;
					tf      = 1'b1;
					tl      = last;
					mode_n  = MODE_PLAIN;
				end
			end
		endcase

		if (last) begin
			mode_n = MODE_GAP;
			fp_n   = 1'b0;
			nl_n   = 1'b0;
		end

		line_wide             = 32'(line_eff);
		result.token_char     = cv ? b : '0;
		result.char_valid     = cv;
		result.token_first    = tf;
		result.token_last     = tl;
		result.newline_before = nl_eff;
		result.line_number    = line_wide[LINE_OUT_BITS-1:0];
		result.number_value   = num_value;
		result.number_valid   = tl && (num_int || (num_start && tf && !cv));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GAP;
			line_q <= '0;
			nl_q   <= 1'b0;
			fp_q   <= 1'b0;
			num_q  <= '{phase: PH_START, negative: 1'b0, accum: '0, saturated: 1'b0};
		end else if (step) begin
			mode_q <= mode_n;
			line_q <= line_n;
			nl_q   <= nl_n;
			fp_q   <= fp_n;
			num_q  <= num_n;
		end
	end
endmodule

>>> rtl/script_byte_tokenizer_unit.sv
// script_byte_tokenizer_unit: top level of the script byte tokenizer
// depends on sbt_pkg, sbt_byte_if, sbt_token_if, sbt_cfg_regs, sbt_lex_core
//
// Takes one script byte per beat and gives at most one token result per byte.
// Sustained rate is one byte per clock while the result side is not stalled;
// an input beat reaches its result through the input register, then the
// result register. The rate is set by the lexer state loop: mode, line count
// and the running integer conversion are updated together from the registered
// byte, so each byte sees the state left by the one before. The input register
// frees up whenever the result register is empty or being taken, so a new byte
// is accepted while the previous result still waits, and stalls only when both
// stages hold data. Bytes that give no result (whitespace, comments, an
// opening quote) still step the lexer state. Comment and quote characters live
// in two apb registers at byte addresses 0 and 4; write them only while idle.
// There is no clearing pass after reset.
module script_byte_tokenizer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbt_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [sbt_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [sbt_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                             pready,
	sbt_byte_if.sink                         byte_in,
	sbt_token_if.source                      token_out
);
	import sbt_pkg::*;

	cfg_t       cfg;
	byte_beat_t beat_s1;
	logic       valid_s1;
	token_t     tok_s2, result;
	logic       valid_s2;
	logic       advance, step, emit, in_fire;

	// result register can take a new value when empty or being drained
	assign advance       = !valid_s2 || token_out.ready;
	assign step          = valid_s1 && advance;
	assign byte_in.ready = !valid_s1 || advance;
	assign in_fire       = byte_in.valid && byte_in.ready;

	sbt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			beat_s1.byte_value      <= byte_in.byte_value;
			beat_s1.first_of_script <= byte_in.first_of_script;
			beat_s1.last_of_script  <= byte_in.last_of_script;
		end
	end

	// lexer state and per-byte decision
	sbt_lex_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.beat   (beat_s1),
		.cfg    (cfg),
		.emit   (emit),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			tok_s2 <= result;
		end
	end

	assign token_out.valid          = valid_s2;
	assign token_out.token_char     = tok_s2.token_char;
	assign token_out.char_valid     = tok_s2.char_valid;
	assign token_out.token_first    = tok_s2.token_first;
	assign token_out.token_last     = tok_s2.token_last;
	assign token_out.newline_before = tok_s2.newline_before;
	assign token_out.line_number    = tok_s2.line_number;
	assign token_out.number_value   = tok_s2.number_value;
	assign token_out.number_valid   = tok_s2.number_valid;
endmodule

>>> rtl/sbt_checker.sv
// sbt_checker: port-level assertions for the tokenizer, bound to the top level
// depends on sbt_pkg and script_byte_tokenizer_unit
module sbt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [sbt_pkg::BYTE_BITS-1:0]     out_char,
	input logic                             out_last,
	input logic [sbt_pkg::LINE_OUT_BITS-1:0] out_line,
	input logic [sbt_pkg::NUM_BITS-1:0]      out_value,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [sbt_pkg::CFG_ADDR_BITS-1:0] paddr,
	input logic [sbt_pkg::CFG_DATA_BITS-1:0] pwdata,
	input logic [sbt_pkg::CFG_DATA_BITS-1:0] prdata
);
	import sbt_pkg::*;

	logic in_acc, cfg_wr;

	assign in_acc = in_valid && in_ready;
	assign cfg_wr = psel && penable && pwrite;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
			&& $stable(out_line) && $stable(out_value))
		else $error("stalled result changed");

	// input back-pressure only when the result side is stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a fresh result comes from an accepted beat held first in the input register
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc, 2))
		else $error("result without a matching input beat");

	// register write reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (paddr != $past(paddr)) ||
			(prdata[BYTE_BITS-1:0] == $past(pwdata[BYTE_BITS-1:0])))
		else $error("register readback mismatch");
endmodule

bind script_byte_tokenizer_unit sbt_checker u_sbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_in.valid),
	.in_ready  (byte_in.ready),
	.out_valid (token_out.valid),
	.out_ready (token_out.ready),
	.out_char  (token_out.token_char),
	.out_last  (token_out.token_last),
	.out_line  (token_out.line_number),
	.out_value (token_out.number_value),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

>>> sim/sbt_token_checker.sv
// sbt_token_checker: predicts the token beats of the script byte tokenizer and checks them
// depends on sbt_pkg, sbt_byte_if and sbt_token_if; watches the apb port for register writes
module sbt_token_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sbt_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [sbt_pkg::CFG_DATA_BITS-1:0] pwdata,
	input  logic [sbt_pkg::CFG_DATA_BITS-1:0] prdata,
	input  logic                              pready,
	sbt_byte_if                               byte_mon,
	sbt_token_if                              token_mon,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sbt_pkg::*;

	cfg_t                 cfg;
	lex_mode_t            mode;
	logic [LINE_BITS-1:0] lines;
	logic                 nl_pending;
	logic                 open_first;
	num_state_t           num;
	token_t               expected_tokens[$];

	function automatic void flag(input string what, input logic [63:0] want,
		input logic [63:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t mismatch on %s: expected %0h, actual %0h", $realtime, what, want, got);
		end
	endfunction

	function automatic bit is_blank(input logic [BYTE_BITS-1:0] b);
		return b == SPACE_BYTE || (b >= 8'd9 && b <= 8'd13);
	endfunction

	// 16 marks a byte that is no hex digit
	function automatic logic [4:0] hex_val(input logic [BYTE_BITS-1:0] b);
		if (b >= "0" && b <= "9") return 5'(b - "0");
		if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
		if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
		return 5'd16;
	endfunction

	function automatic void num_reset();
		num.phase     = PH_START;
		num.negative  = 1'b0;
		num.accum     = '0;
		num.saturated = 1'b0;
	endfunction

	// magnitude sticks at 2^31 once it overflows
	function automatic void num_push(input int unsigned base, input logic [4:0] d);
		logic [63:0] v;
		v = 64'(num.accum) * 64'(base) + 64'(d);
		if (num.saturated || v > 64'(MAG_CAP)) begin
			num.accum     = MAG_CAP;
			num.saturated = 1'b1;
		end else begin
			num.accum = v[NUM_BITS-1:0];
		end
	endfunction

	function automatic void num_feed(input logic [BYTE_BITS-1:0] b);
		logic [4:0] h;
		bit         dec;
		bit         oct;
		bit         lead;
		h    = hex_val(b);
		dec  = b >= "0" && b <= "9";
		oct  = b >= "0" && b <= "7";
		lead = 1'b0;
		case (num.phase)
			PH_START: begin
				if (!is_blank(b)) begin
					if (b == "+") begin
						num.phase = PH_SIGN;
					end else if (b == "-") begin
						num.negative = 1'b1;
						num.phase    = PH_SIGN;
					end else begin
						lead = 1'b1;
					end
				end
			end
			PH_SIGN: lead = 1'b1;
			PH_ZERO: begin
				if (b == "x" || b == "X") begin
					num.phase = PH_HEXPFX;
				end else if (oct) begin
					num_push(8, h);
					num.phase = PH_OCT;
				end else begin
					num.phase = PH_BAD;
				end
			end
			PH_HEXPFX, PH_HEX: begin
				if (h < 5'd16) begin
					num_push(16, h);
					num.phase = PH_HEX;
				end else begin
					num.phase = PH_BAD;
				end
			end
			PH_DEC: begin
				if (dec) num_push(10, h);
				else num.phase = PH_BAD;
			end
			PH_OCT: begin
				if (oct) num_push(8, h);
				else num.phase = PH_BAD;
			end
			default: num.phase = PH_BAD;
		endcase
		// first byte after optional blanks and sign picks the base
		if (lead) begin
			if (b == "0") begin
				num.phase = PH_ZERO;
			end else if (dec) begin
				num_push(10, h);
				num.phase = PH_DEC;
			end else begin
				num.phase = PH_BAD;
			end
		end
	endfunction

	function automatic logic signed [NUM_BITS-1:0] num_value();
		if (num.negative) return (num.accum >= MAG_CAP) ? MAG_CAP : -num.accum;
		return (num.accum > POS_MAX) ? POS_MAX : num.accum;
	endfunction

	function automatic bit num_ok(input bit empty);
		return num.phase == PH_ZERO || num.phase == PH_DEC || num.phase == PH_OCT ||
			num.phase == PH_HEX || (num.phase == PH_START && empty);
	endfunction

	function automatic token_t make_token(input logic [BYTE_BITS-1:0] ch, input bit cv,
		input bit first, input bit last);
		token_t t;
		t.token_char     = cv ? ch : '0;
		t.char_valid     = cv;
		t.token_first    = first;
		t.token_last     = last;
		t.newline_before = nl_pending;
		t.line_number    = lines[LINE_OUT_BITS-1:0];
		t.number_value   = num_value();
		t.number_valid   = last && num_ok(first && !cv);
		return t;
	endfunction

	function automatic void bump_line();
		if (lines != '1) lines++;
		nl_pending = 1'b1;
	endfunction

	// one script byte in, at most one token beat out
	function automatic bit predict_token(input logic [BYTE_BITS-1:0] b, input logic start,
		input logic stop, output token_t t);
		bit has;
		bit gap;
		has = 1'b0;
		gap = 1'b0;
		t   = '0;
		if (start) begin
			mode       = MODE_GAP;
			lines      = LINE_BITS'(1);
			nl_pending = 1'b0;
			open_first = 1'b0;
			num_reset();
		end
		case (mode)
			MODE_COMMENT: begin
				if (b == NL_BYTE) begin
					bump_line();
					mode = MODE_GAP;
				end
			end
			MODE_PLAIN: begin
				if (b <= SPACE_BYTE || b == cfg.comment_char) begin
					t          = make_token('0, 1'b0, 1'b0, 1'b1);
					has        = 1'b1;
					nl_pending = 1'b0;
					mode       = MODE_GAP;
					gap        = 1'b1;
				end else begin
					num_feed(b);
					t   = make_token(b, 1'b1, 1'b0, stop);
					has = 1'b1;
				end
			end
			MODE_QUOTED: begin
				if (b == cfg.quote_char) begin
					t          = make_token('0, 1'b0, open_first, 1'b1);
					has        = 1'b1;
					nl_pending = 1'b0;
					mode       = MODE_GAP;
				end else begin
					num_feed(b);
					t   = make_token(b, 1'b1, open_first, stop);
					has = 1'b1;
				end
				open_first = 1'b0;
			end
			default: gap = 1'b1;
		endcase
		if (gap) begin
			if (b <= SPACE_BYTE) begin
				if (b == NL_BYTE) bump_line();
			end else if (b == cfg.comment_char) begin
				mode = MODE_COMMENT;
			end else if (!has && b == cfg.quote_char) begin
				num_reset();
				if (stop) begin
					t   = make_token('0, 1'b0, 1'b1, 1'b1);
					has = 1'b1;
				end else begin
					mode       = MODE_QUOTED;
					open_first = 1'b1;
				end
			end else if (!has) begin
				num_reset();
				num_feed(b);
				t    = make_token(b, 1'b1, 1'b1, stop);
				has  = 1'b1;
				mode = MODE_PLAIN;
			end
		end
		if (stop) begin
			mode       = MODE_GAP;
			open_first = 1'b0;
			nl_pending = 1'b0;
		end
		return has;
	endfunction

	function automatic void compare_token(input token_t want, input token_t got);
		if (got.token_char != want.token_char) flag("token_char", want.token_char, got.token_char);
		if (got.char_valid != want.char_valid) flag("char_valid", want.char_valid, got.char_valid);
		if (got.token_first != want.token_first)
			flag("token_first", want.token_first, got.token_first);
		if (got.token_last != want.token_last) flag("token_last", want.token_last, got.token_last);
		if (got.newline_before != want.newline_before)
			flag("newline_before", want.newline_before, got.newline_before);
		if (got.line_number != want.line_number)
			flag("line_number", want.line_number, got.line_number);
		if (got.number_value != want.number_value)
			flag("number_value", want.number_value, got.number_value);
		if (got.number_valid != want.number_valid)
			flag("number_valid", want.number_valid, got.number_valid);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t      want;
		token_t      got;
		int unsigned ridx;
		if (!arst_n) begin
			cfg.comment_char = COMMENT_RESET;
			cfg.quote_char   = QUOTE_RESET;
			mode             = MODE_GAP;
			lines            = '0;
			nl_pending       = 1'b0;
			open_first       = 1'b0;
			num_reset();
			expected_tokens.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready) begin
				ridx = paddr >> CFG_IDX_LSB;
				if (pwrite) begin
					if (ridx == CFG_COMMENT) cfg.comment_char = pwdata[BYTE_BITS-1:0];
					else if (ridx == CFG_QUOTE) cfg.quote_char = pwdata[BYTE_BITS-1:0];
				end else if (ridx == CFG_COMMENT) begin
					if (prdata[BYTE_BITS-1:0] != cfg.comment_char)
						flag("comment_char read", cfg.comment_char, prdata);
				end else if (ridx == CFG_QUOTE) begin
					if (prdata[BYTE_BITS-1:0] != cfg.quote_char)
						flag("quote_char read", cfg.quote_char, prdata);
				end
			end
			if (byte_mon.valid && byte_mon.ready) begin
				if (predict_token(byte_mon.byte_value, byte_mon.first_of_script,
					byte_mon.last_of_script, want))
					expected_tokens.push_back(want);
			end
			if (token_mon.valid && token_mon.ready) begin
				got.token_char     = token_mon.token_char;
				got.char_valid     = token_mon.char_valid;
				got.token_first    = token_mon.token_first;
				got.token_last     = token_mon.token_last;
				got.newline_before = token_mon.newline_before;
				got.line_number    = token_mon.line_number;
				got.number_value   = token_mon.number_value;
				got.number_valid   = token_mon.number_valid;
				if (expected_tokens.size() == 0) flag("unexpected beat", '0, got.token_char);
				else compare_token(expected_tokens.pop_front(), got);
			end
			pending = expected_tokens.size();
		end
	end

endmodule

>>> sim/script_byte_tokenizer_unit_test.sv
// script_byte_tokenizer_unit_test: top of the tokenizer bench, makes clock, reset, stimulus
// depends on sbt_pkg, sbt_byte_if, sbt_token_if, sbt_token_checker and the tokenizer rtl
module script_byte_tokenizer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sbt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 400;   // beats sent before the long sink hold-off
	localparam int HOLD_CYCLES = 250;
	localparam int PHASE_BEATS = 265;
	localparam int PHASES      = 6;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	int                       fail_count;
	int                       pending;
	int                       beats_sent;
	int                       cycles;
	bit                       calm;          // no idling on either side while set
	logic [BYTE_BITS-1:0]     cur_comment;   // register values the generator aims at
	logic [BYTE_BITS-1:0]     cur_quote;
	logic [BYTE_BITS-1:0]     script_text[$];

	sbt_byte_if  byte_ch ();
	sbt_token_if token_ch ();

	script_byte_tokenizer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.byte_in   (byte_ch),
		.token_out (token_ch)
	);

	sbt_token_checker check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.byte_mon   (byte_ch),
		.token_mon  (token_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost beat ends here
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// sink side: random ready, one long hold-off once the stream is going so the
	// result register and the input register both fill and byte_in.ready drops
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		token_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && beats_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				token_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				token_ch.ready <= calm || $urandom_range(99) >= 9;
			end
		end
	end

	// apb write in setup and access cycles, then a read back of the same register;
	// psel stays up between the two so no signal gets two updates in one step
	task automatic reg_set(input cfg_idx_t idx, input logic [BYTE_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_BITS'(int'(idx) << CFG_IDX_LSB);
		pwdata  <= CFG_DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// one beat; valid stays high from one beat to the next unless an idle cycle falls between
	task automatic send_byte(input logic [BYTE_BITS-1:0] value, input logic start,
		input logic stop);
		while (!calm && $urandom_range(99) < 9) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid           <= 1'b1;
		byte_ch.byte_value      <= value;
		byte_ch.first_of_script <= start;
		byte_ch.last_of_script  <= stop;
		do @(posedge clk); while (!byte_ch.ready);
		beats_sent++;
	endtask

	task automatic send_script(input bit mark_first, input bit mark_last);
		foreach (script_text[i])
			send_byte(script_text[i], mark_first && i == 0,
				mark_last && i == script_text.size() - 1);
		script_text.delete();
	endtask

	task automatic add_str(input string s);
		foreach (s[i]) script_text.push_back(s[i]);
	endtask

	// whitespace between tokens; zero bytes of it glue two tokens together
	task automatic add_gap();
		repeat ($urandom_range(2)) begin
			case ($urandom_range(5))
				0: script_text.push_back("\n");
				1: script_text.push_back("\t");
				2: script_text.push_back("\r");
				3: script_text.push_back(8'($urandom_range(32)));
				default: script_text.push_back(" ");
			endcase
		end
	endtask

	// one token or comment with random content, often numbers in some base
	task automatic add_piece();
		int    n;
		string hex_digits;
		hex_digits = "0123456789abcdefABCDEF";
		case ($urandom_range(6))
			0: begin
				// decimal, now and then long enough to saturate
				if ($urandom_range(2) == 0) script_text.push_back($urandom_range(1) ? "-" : "+");
				n = ($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
				script_text.push_back(8'($urandom_range(49, 57)));
				repeat (n - 1) script_text.push_back(8'($urandom_range(48, 57)));
			end
			1: begin
				if ($urandom_range(3) == 0) script_text.push_back("-");
				add_str($urandom_range(1) ? "0x" : "0X");
				n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(4);
				repeat (n) script_text.push_back(hex_digits[$urandom_range(21)]);
			end
			2: begin
				if ($urandom_range(3) == 0) script_text.push_back("-");
				script_text.push_back("0");
				n = ($urandom_range(7) == 0) ? $urandom_range(11, 13) : $urandom_range(3);
				repeat (n) script_text.push_back(8'($urandom_range(48, 55)));
			end
			3: begin
				// plain word, high bytes included
				repeat ($urandom_range(1, 6))
					script_text.push_back(($urandom_range(4) == 0) ?
						8'($urandom_range(128, 255)) : 8'($urandom_range(33, 126)));
			end
			4: begin
				// quoted text with blanks and newlines inside, sometimes left open
				script_text.push_back(cur_quote);
				repeat ($urandom_range(5)) begin
					case ($urandom_range(5))
						0: script_text.push_back(" ");
						1: script_text.push_back("\n");
						2: script_text.push_back(8'($urandom_range(48, 57)));
						default: script_text.push_back(8'($urandom_range(33, 126)));
					endcase
				end
				if ($urandom_range(9) != 0) script_text.push_back(cur_quote);
			end
			5: begin
				script_text.push_back(cur_comment);
				repeat ($urandom_range(5)) script_text.push_back(8'($urandom_range(32, 126)));
				script_text.push_back("\n");
			end
			default: begin
				// almost-numbers that must come out invalid, beside one valid signed hex number
				case ($urandom_range(5))
					0: add_str("0x");
					1: add_str("-");
					2: add_str("09");
					3: add_str("12z");
					4: add_str("+0x1F");
					default: add_str("--1");
				endcase
			end
		endcase
	endtask

	task automatic build_script();
		repeat ($urandom_range(1, 8)) begin
			add_gap();
			add_piece();
		end
		if ($urandom_range(1)) add_gap();
	endtask

	// drop valid, wait for every predicted beat, then let the pipe run dry
	task automatic drain();
		byte_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		int phase_end;
		beats_sent               = 0;
		calm                     = 1'b0;
		cur_comment              = COMMENT_RESET;
		cur_quote                = QUOTE_RESET;
		arst_n                  <= 1'b0;
		psel                    <= 1'b0;
		penable                 <= 1'b0;
		pwrite                  <= 1'b0;
		paddr                   <= '0;
		pwdata                  <= '0;
		byte_ch.valid           <= 1'b0;
		byte_ch.byte_value      <= '0;
		byte_ch.first_of_script <= 1'b0;
		byte_ch.last_of_script  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset register values
		// signed number closed by a blank, empty quotes, high byte, comment, newline,
		// then a token on the final byte
		add_str("-12 \"\"");
		script_text.push_back(8'hff);
		add_str(";x\n0");
		send_script(1'b1, 1'b1);
		// zero byte as blank, quoted blank that is no number, quote on the final byte
		script_text.push_back(8'h00);
		add_str("\" \"\"");
		send_script(1'b1, 1'b1);
		// quote left open until script end, newline inside not counted
		add_str("\"x\ny");
		send_script(1'b1, 1'b1);
		// no restart mark: old line count, comment ends with the script
		add_str("7;c");
		send_script(1'b0, 1'b1);
		// restart in the middle of a token drops it without an end beat
		add_str("ab");
		send_script(1'b1, 1'b0);
		add_str("42");
		send_script(1'b1, 1'b1);

		// random part, one register setting per phase, extremes among them
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin cur_comment = COMMENT_RESET; cur_quote = QUOTE_RESET; end
				1: begin cur_comment = 8'd0;   cur_quote = 8'd255; end
				2: begin cur_comment = 8'd255; cur_quote = 8'd0; end
				3: begin cur_comment = SPACE_BYTE; cur_quote = SPACE_BYTE; end
				4: begin cur_comment = "#";    cur_quote = "#"; end
				default: begin cur_comment = "/"; cur_quote = "'"; end
			endcase
			reg_set(CFG_COMMENT, cur_comment);
			reg_set(CFG_QUOTE, cur_quote);
			calm      = (p == 2);
			phase_end = beats_sent + PHASE_BEATS;
			while (beats_sent < phase_end) begin
				if ($urandom_range(99) < 12) begin
					// raw noise with stray script marks
					repeat ($urandom_range(1, 12))
						send_byte(8'($urandom_range(255)), $urandom_range(7) == 0,
							$urandom_range(7) == 0);
				end else begin
					build_script();
					send_script($urandom_range(99) >= 8, $urandom_range(99) >= 5);
				end
			end
		end
		calm = 1'b0;
		drain();

		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
